### hdl/drfm_pkg.sv
package drfm_pkg;

  localparam int MAX_CANDIDATES = 16;
  localparam int POS_W          = $clog2(MAX_CANDIDATES + 1);

  localparam int ETA_W      = 14;
  localparam int PHI_W      = 13;
  localparam int THR_W      = 13;
  localparam int MASS_W     = 16;
  localparam int SCORE_W    = 16;
  localparam int IDX_W      = 4;
  localparam int DETA_W     = ETA_W + 1;
  localparam int DPHI_W     = PHI_W + 1;
  localparam int DETA_SQ_W  = 28;
  localparam int DPHI_SQ_W  = 26;
  localparam int SUM_W      = DETA_SQ_W + 1;
  localparam int THR_SQ_W   = 2 * THR_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Q.10 angles, round to nearest
  localparam int PI_Q10     = 3217;
  localparam int TWO_PI_Q10 = 6434;

  localparam logic [THR_W-1:0]   DR_THRESHOLD_RST = THR_W'(819);
  localparam logic [MASS_W-1:0]  MASS_MIN_RST     = '0;
  localparam logic [MASS_W-1:0]  MASS_MAX_RST     = '1;
  localparam logic [SCORE_W-1:0] SCORE_MIN_RST    = '0;
  localparam logic [SCORE_W-1:0] SCORE_MAX_RST    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DR_THRESHOLD     = 3'd0,
    REG_MASS_MIN         = 3'd1,
    REG_MASS_MAX         = 3'd2,
    REG_SCORE_MIN        = 3'd3,
    REG_SCORE_MAX        = 3'd4,
    REG_USE_MASS_WINDOW  = 3'd5,
    REG_USE_SCORE_WINDOW = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                   first;
    logic                   present;
    logic                   last;
    logic                   win_ok;
    logic [DETA_SQ_W-1:0]   deta_sq;
    logic [DPHI_SQ_W-1:0]   dphi_sq;
  } sq_stage_t;

endpackage

### hdl/drfm_item_if.sv
interface drfm_item_if;
  logic                                valid;
  logic                                ready;
  logic                                first;
  logic signed [drfm_pkg::ETA_W-1:0]   ref_eta;
  logic signed [drfm_pkg::PHI_W-1:0]   ref_phi;
  logic                                present;
  logic signed [drfm_pkg::ETA_W-1:0]   cand_eta;
  logic signed [drfm_pkg::PHI_W-1:0]   cand_phi;
  logic        [drfm_pkg::MASS_W-1:0]  cand_mass;
  logic        [drfm_pkg::SCORE_W-1:0] cand_score;
  logic                                last;

  modport source (
    output valid, first, ref_eta, ref_phi, present, cand_eta, cand_phi,
           cand_mass, cand_score, last,
    input  ready
  );
  modport sink (
    input  valid, first, ref_eta, ref_phi, present, cand_eta, cand_phi,
           cand_mass, cand_score, last,
    output ready
  );
endinterface

### hdl/drfm_result_if.sv
interface drfm_result_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [drfm_pkg::IDX_W-1:0]     match_index;
  logic                           overflow;

  modport source (output valid, found, match_index, overflow, input ready);
  modport sink   (input  valid, found, match_index, overflow, output ready);
endinterface

### hdl/drfm_cfg_if.sv
interface drfm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [drfm_pkg::CFG_IDX_W-1:0]    index;
  logic [drfm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

### hdl/delta_r_first_match.sv
// Path from item acceptance to result valid: the input register feeds the square
// stage, whose match update loads the result register.
// Throughput: one item per cycle; only an end-of-event item waits in the square
// stage while a result is held, which stalls the input behind it.
// Reset (rst, synchronous): pipeline empty, event state and latched reference
// cleared, configuration registers back to their defaults.
module delta_r_first_match (
  input  logic                  clk,
  input  logic                  rst,
  drfm_item_if.sink             items,
  drfm_result_if.source         results,
  drfm_cfg_if.sink              cfg
);

  // configuration
  logic [drfm_pkg::THR_W-1:0]    dr_threshold;
  logic [drfm_pkg::MASS_W-1:0]   mass_min;
  logic [drfm_pkg::MASS_W-1:0]   mass_max;
  logic [drfm_pkg::SCORE_W-1:0]  score_min;
  logic [drfm_pkg::SCORE_W-1:0]  score_max;
  logic                          use_mass_window;
  logic                          use_score_window;
  logic [drfm_pkg::THR_SQ_W-1:0] thr_sq;

  // input register
  logic                                 in_valid;
  logic                                 in_first;
  logic signed [drfm_pkg::ETA_W-1:0]    in_ref_eta;
  logic signed [drfm_pkg::PHI_W-1:0]    in_ref_phi;
  logic                                 in_present;
  logic signed [drfm_pkg::ETA_W-1:0]    in_cand_eta;
  logic signed [drfm_pkg::PHI_W-1:0]    in_cand_phi;
  logic [drfm_pkg::MASS_W-1:0]          in_cand_mass;
  logic [drfm_pkg::SCORE_W-1:0]         in_cand_score;
  logic                                 in_last;

  // square stage
  logic                    sq_valid;
  drfm_pkg::sq_stage_t     sq;
  drfm_pkg::sq_stage_t     sq_next;

  // event state
  logic signed [drfm_pkg::ETA_W-1:0] latched_eta;
  logic signed [drfm_pkg::PHI_W-1:0] latched_phi;
  logic [drfm_pkg::POS_W-1:0]        position;
  logic                              have_match;
  logic [drfm_pkg::IDX_W-1:0]        best_index;
  logic                              too_many;
  logic [drfm_pkg::POS_W-1:0]        position_next;
  logic                              have_match_next;
  logic [drfm_pkg::IDX_W-1:0]        best_index_next;
  logic                              too_many_next;

  // result register
  logic                              out_valid;
  logic                              found;
  logic [drfm_pkg::IDX_W-1:0]        match_index;
  logic                              overflow;

  // handshake
  logic out_free, sq_adv, sq_take, in_adv;

  assign out_free = !out_valid || results.ready;
  assign sq_adv   = sq_valid && (!sq.last || out_free);
  assign sq_take  = !sq_valid || sq_adv;
  assign in_adv   = in_valid && sq_take;
  assign items.ready = !in_valid || in_adv;
  assign cfg.ready   = 1'b1;

  assign results.valid       = out_valid;
  assign results.found       = found;
  assign results.match_index = match_index;
  assign results.overflow    = overflow;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dr_threshold     <= drfm_pkg::DR_THRESHOLD_RST;
      mass_min         <= drfm_pkg::MASS_MIN_RST;
      mass_max         <= drfm_pkg::MASS_MAX_RST;
      score_min        <= drfm_pkg::SCORE_MIN_RST;
      score_max        <= drfm_pkg::SCORE_MAX_RST;
      use_mass_window  <= 1'b0;
      use_score_window <= 1'b0;
    end else if (cfg.valid) begin
      unique case (drfm_pkg::cfg_reg_t'(cfg.index))
        drfm_pkg::REG_DR_THRESHOLD:     dr_threshold     <= cfg.data[drfm_pkg::THR_W-1:0];
        drfm_pkg::REG_MASS_MIN:         mass_min         <= cfg.data[drfm_pkg::MASS_W-1:0];
        drfm_pkg::REG_MASS_MAX:         mass_max         <= cfg.data[drfm_pkg::MASS_W-1:0];
        drfm_pkg::REG_SCORE_MIN:        score_min        <= cfg.data[drfm_pkg::SCORE_W-1:0];
        drfm_pkg::REG_SCORE_MAX:        score_max        <= cfg.data[drfm_pkg::SCORE_W-1:0];
        drfm_pkg::REG_USE_MASS_WINDOW:  use_mass_window  <= cfg.data[0];
        drfm_pkg::REG_USE_SCORE_WINDOW: use_score_window <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // squared limit, settles well before the next item after a write
  always_ff @(posedge clk) begin
    thr_sq <= drfm_pkg::THR_SQ_W'(dr_threshold * dr_threshold);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      in_first      <= items.first;
      in_ref_eta    <= items.ref_eta;
      in_ref_phi    <= items.ref_phi;
      in_present    <= items.present;
      in_cand_eta   <= items.cand_eta;
      in_cand_phi   <= items.cand_phi;
      in_cand_mass  <= items.cand_mass;
      in_cand_score <= items.cand_score;
      in_last       <= items.last;
    end
  end

  // square stage: differences, phi wrap, squares and windows
  logic signed [drfm_pkg::ETA_W-1:0]       eta_ref;
  logic signed [drfm_pkg::PHI_W-1:0]       phi_ref;
  logic signed [drfm_pkg::DETA_W-1:0]      deta;
  logic signed [drfm_pkg::DPHI_W-1:0]      dphi_raw;
  logic        [drfm_pkg::DPHI_W-1:0]      dphi_abs;
  logic signed [drfm_pkg::DPHI_W-1:0]      dphi;
  logic signed [2*drfm_pkg::DETA_W-1:0]    deta_prod;
  logic signed [2*drfm_pkg::DPHI_W-1:0]    dphi_prod;
  logic                                    mass_ok, score_ok;

  always_comb begin
    eta_ref  = in_first ? in_ref_eta : latched_eta;
    phi_ref  = in_first ? in_ref_phi : latched_phi;
    deta     = drfm_pkg::DETA_W'(eta_ref) - drfm_pkg::DETA_W'(in_cand_eta);
    dphi_raw = drfm_pkg::DPHI_W'(phi_ref) - drfm_pkg::DPHI_W'(in_cand_phi);
    dphi_abs = dphi_raw[drfm_pkg::DPHI_W-1] ? drfm_pkg::DPHI_W'(-dphi_raw)
                                            : drfm_pkg::DPHI_W'(dphi_raw);
    // wrap past pi; may go negative when the difference exceeds 2pi
    if (dphi_abs >= drfm_pkg::DPHI_W'(drfm_pkg::PI_Q10)) begin
      dphi = $signed(drfm_pkg::DPHI_W'(drfm_pkg::TWO_PI_Q10) - dphi_abs);
    end else begin
      dphi = $signed(dphi_abs);
    end
    deta_prod = deta * deta;
    dphi_prod = dphi * dphi;

    mass_ok  = !use_mass_window ||
               (in_cand_mass > mass_min && in_cand_mass < mass_max);
    score_ok = !use_score_window ||
               (in_cand_score > score_min && in_cand_score < score_max);

    sq_next.first   = in_first;
    sq_next.present = in_present;
    sq_next.last    = in_last;
    sq_next.win_ok  = mass_ok && score_ok;
    sq_next.deta_sq = deta_prod[drfm_pkg::DETA_SQ_W-1:0];
    sq_next.dphi_sq = dphi_prod[drfm_pkg::DPHI_SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid    <= 1'b0;
      latched_eta <= '0;
      latched_phi <= '0;
    end else if (sq_take) begin
      sq_valid <= in_valid;
      if (in_valid && in_first) begin
        latched_eta <= in_ref_eta;
        latched_phi <= in_ref_phi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      sq <= sq_next;
    end
  end

  // match update
  logic [drfm_pkg::SUM_W-1:0]  dist_sq;
  logic                        hit;
  logic [drfm_pkg::POS_W-1:0]  pos_cur;
  logic                        hm_cur;
  logic [drfm_pkg::IDX_W-1:0]  bi_cur;
  logic                        tm_cur;

  always_comb begin
    dist_sq = drfm_pkg::SUM_W'(sq.deta_sq) + drfm_pkg::SUM_W'(sq.dphi_sq);
    hit     = sq.win_ok && (dist_sq < drfm_pkg::SUM_W'(thr_sq));

    pos_cur = sq.first ? '0   : position;
    hm_cur  = sq.first ? 1'b0 : have_match;
    bi_cur  = sq.first ? '0   : best_index;
    tm_cur  = sq.first ? 1'b0 : too_many;

    position_next   = pos_cur;
    have_match_next = hm_cur;
    best_index_next = bi_cur;
    too_many_next   = tm_cur;

    if (sq.present) begin
      if (pos_cur < drfm_pkg::POS_W'(drfm_pkg::MAX_CANDIDATES)) begin
        if (hit && !hm_cur) begin
          have_match_next = 1'b1;
          best_index_next = drfm_pkg::IDX_W'(pos_cur);
        end
        position_next = pos_cur + 1'b1;
      end else begin
        too_many_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      have_match <= 1'b0;
      best_index <= '0;
      too_many   <= 1'b0;
    end else if (sq_adv) begin
      if (sq.last) begin
        position   <= '0;
        have_match <= 1'b0;
        best_index <= '0;
        too_many   <= 1'b0;
      end else begin
        position   <= position_next;
        have_match <= have_match_next;
        best_index <= best_index_next;
        too_many   <= too_many_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= sq_adv && sq.last;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_adv && sq.last) begin
      found       <= have_match_next;
      match_index <= have_match_next ? best_index_next : '0;
      overflow    <= too_many_next;
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY        = 3;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 190;
  localparam int PH_PRESSURE    = 3;
  localparam int PH_STEADY      = 5;
  localparam int IDLE_PCT       = 37;
  localparam int ETA_SPAN       = 5120;
  localparam int NEAR_SPAN      = 1000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [drfm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic                                first;
    logic signed [drfm_pkg::ETA_W-1:0]   ref_eta;
    logic signed [drfm_pkg::PHI_W-1:0]   ref_phi;
    logic                                present;
    logic signed [drfm_pkg::ETA_W-1:0]   cand_eta;
    logic signed [drfm_pkg::PHI_W-1:0]   cand_phi;
    logic        [drfm_pkg::MASS_W-1:0]  cand_mass;
    logic        [drfm_pkg::SCORE_W-1:0] cand_score;
    logic                                last;
  } cand_item_t;

  typedef struct {
    logic                       found;
    logic [drfm_pkg::IDX_W-1:0] match_index;
    logic                       overflow;
  } match_result_t;

  typedef struct {
    bit                              is_cfg;
    logic [drfm_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [drfm_pkg::CFG_DATA_W-1:0] reg_data;
    cand_item_t                      item;
    bit                              typed;
    match_result_t                   result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  drfm_item_if   item_ch ();
  drfm_result_if res_ch ();
  drfm_cfg_if    cfg_ch ();

  delta_r_first_match dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // register mirror
  logic [drfm_pkg::THR_W-1:0]   dr_limit   = drfm_pkg::DR_THRESHOLD_RST;
  logic [drfm_pkg::MASS_W-1:0]  mass_lo    = drfm_pkg::MASS_MIN_RST;
  logic [drfm_pkg::MASS_W-1:0]  mass_hi    = drfm_pkg::MASS_MAX_RST;
  logic [drfm_pkg::SCORE_W-1:0] score_lo   = drfm_pkg::SCORE_MIN_RST;
  logic [drfm_pkg::SCORE_W-1:0] score_hi   = drfm_pkg::SCORE_MAX_RST;
  logic                         mass_gate  = 1'b0;
  logic                         score_gate = 1'b0;

  // event tracking mirror
  logic signed [drfm_pkg::ETA_W-1:0] held_eta   = '0;
  logic signed [drfm_pkg::PHI_W-1:0] held_phi   = '0;
  logic [drfm_pkg::POS_W-1:0]        cand_count = '0;
  logic                              matched    = 1'b0;
  logic [drfm_pkg::POS_W-1:0]        match_pos  = '0;
  logic                              excess     = 1'b0;

  match_result_t           expected_results[$];
  stim_row_t               directed_rows[$];

  logic signed [drfm_pkg::ETA_W-1:0] gen_ref_eta = '0;
  logic signed [drfm_pkg::PHI_W-1:0] gen_ref_phi = '0;

  bit steady_send  = 1'b0;
  bit steady_recv  = 1'b0;
  bit hold_request = 1'b0;

  int items_sent     = 0;
  int results_seen   = 0;
  int found_seen     = 0;
  int overflow_seen  = 0;
  int settings_used  = 1;
  int fault_count    = 0;
  int quiet_cycles   = 0;

  function automatic void log_fault(input string text);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("%s", text);
  endfunction

  function automatic bit predict_match(input cand_item_t it, output match_result_t res);
    longint deta;
    longint dphi;
    longint limit_sq;
    bit     hit;
    res = '{default: '0};
    if (it.first) begin
      held_eta   = it.ref_eta;
      held_phi   = it.ref_phi;
      cand_count = '0;
      matched    = 1'b0;
      match_pos  = '0;
      excess     = 1'b0;
    end
    if (it.present) begin
      if (cand_count < drfm_pkg::MAX_CANDIDATES) begin
        deta = longint'(held_eta) - longint'(it.cand_eta);
        dphi = longint'(held_phi) - longint'(it.cand_phi);
        if (dphi < 0)
          dphi = -dphi;
        // wrap around the circle; past 2pi this goes negative, square it anyway
        if (dphi >= drfm_pkg::PI_Q10)
          dphi = drfm_pkg::TWO_PI_Q10 - dphi;
        limit_sq = longint'(dr_limit) * longint'(dr_limit);
        hit = (deta * deta + dphi * dphi) < limit_sq;
        if (mass_gate && !(it.cand_mass > mass_lo && it.cand_mass < mass_hi))
          hit = 1'b0;
        if (score_gate && !(it.cand_score > score_lo && it.cand_score < score_hi))
          hit = 1'b0;
        if (hit && !matched) begin
          matched   = 1'b1;
          match_pos = cand_count;
        end
        cand_count++;
      end else begin
        excess = 1'b1;
      end
    end
    if (it.last) begin
      res.found       = matched;
      res.match_index = matched ? match_pos[drfm_pkg::IDX_W-1:0] : '0;
      res.overflow    = excess;
      cand_count      = '0;
      matched         = 1'b0;
      match_pos       = '0;
      excess          = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [drfm_pkg::MASS_W-1:0] pick_near(
      input logic [drfm_pkg::MASS_W-1:0] lo,
      input logic [drfm_pkg::MASS_W-1:0] hi);
    case ($urandom_range(5))
      0: return lo;
      1: return lo + 1'b1;
      2: return hi - 1'b1;
      3: return hi;
      default: return drfm_pkg::MASS_W'($urandom);
    endcase
  endfunction

  function automatic void add_row(input bit first, input int reta, input int rphi,
                                  input bit present, input int ceta, input int cphi,
                                  input bit last, input bit typed = 1'b0,
                                  input bit found = 1'b0, input int index = 0,
                                  input bit ovf = 1'b0, input int mass = 'h1234,
                                  input int score = 'h8000);
    stim_row_t row;
    row.is_cfg                = 1'b0;
    row.reg_idx               = '0;
    row.reg_data              = '0;
    row.item.first            = first;
    row.item.ref_eta          = drfm_pkg::ETA_W'(reta);
    row.item.ref_phi          = drfm_pkg::PHI_W'(rphi);
    row.item.present          = present;
    row.item.cand_eta         = drfm_pkg::ETA_W'(ceta);
    row.item.cand_phi         = drfm_pkg::PHI_W'(cphi);
    row.item.cand_mass        = drfm_pkg::MASS_W'(mass);
    row.item.cand_score       = drfm_pkg::SCORE_W'(score);
    row.item.last             = last;
    row.typed                 = typed;
    row.result.found          = found;
    row.result.match_index    = drfm_pkg::IDX_W'(index);
    row.result.overflow       = ovf;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_cfg_row(input logic [drfm_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [drfm_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row          = '{default: '0};
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic offer_item(input cand_item_t it, input bit typed,
                            input match_result_t typed_res);
    match_result_t predicted;
    while (!steady_send && $urandom_range(99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.first      <= it.first;
    item_ch.ref_eta    <= it.ref_eta;
    item_ch.ref_phi    <= it.ref_phi;
    item_ch.present    <= it.present;
    item_ch.cand_eta   <= it.cand_eta;
    item_ch.cand_phi   <= it.cand_phi;
    item_ch.cand_mass  <= it.cand_mass;
    item_ch.cand_score <= it.cand_score;
    item_ch.last       <= it.last;
    @(posedge clk);
    while (!item_ch.ready)
      @(posedge clk);
    items_sent++;
    if (predict_match(it, predicted))
      expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
  endtask

  task automatic cfg_write(input logic [drfm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drfm_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready)
      @(posedge clk);
    case (idx)
      drfm_pkg::REG_DR_THRESHOLD:     dr_limit   = data[drfm_pkg::THR_W-1:0];
      drfm_pkg::REG_MASS_MIN:         mass_lo    = data[drfm_pkg::MASS_W-1:0];
      drfm_pkg::REG_MASS_MAX:         mass_hi    = data[drfm_pkg::MASS_W-1:0];
      drfm_pkg::REG_SCORE_MIN:        score_lo   = data[drfm_pkg::SCORE_W-1:0];
      drfm_pkg::REG_SCORE_MAX:        score_hi   = data[drfm_pkg::SCORE_W-1:0];
      drfm_pkg::REG_USE_MASS_WINDOW:  mass_gate  = data[0];
      drfm_pkg::REG_USE_SCORE_WINDOW: score_gate = data[0];
      default: ;
    endcase
  endtask

  // drop valid, wait for every result, then let the pipeline run dry
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic configure_phase(input int ph);
    logic [drfm_pkg::CFG_DATA_W-1:0] thr_d;
    logic [drfm_pkg::CFG_DATA_W-1:0] mlo;
    logic [drfm_pkg::CFG_DATA_W-1:0] mhi;
    logic [drfm_pkg::CFG_DATA_W-1:0] slo;
    logic [drfm_pkg::CFG_DATA_W-1:0] shi;
    logic [drfm_pkg::CFG_DATA_W-1:0] mflag;
    logic [drfm_pkg::CFG_DATA_W-1:0] sflag;
    thr_d = drfm_pkg::CFG_DATA_W'($urandom_range(300, 2500));
    mlo   = drfm_pkg::CFG_DATA_W'($urandom_range(30000));
    mhi   = mlo + drfm_pkg::CFG_DATA_W'($urandom_range(1, 35000));
    slo   = drfm_pkg::CFG_DATA_W'($urandom_range(30000));
    shi   = slo + drfm_pkg::CFG_DATA_W'($urandom_range(1, 35000));
    mflag = drfm_pkg::CFG_DATA_W'($urandom_range(1));
    sflag = drfm_pkg::CFG_DATA_W'($urandom_range(1));
    case (ph)
      0: begin
        thr_d = drfm_pkg::CFG_DATA_W'(drfm_pkg::DR_THRESHOLD_RST);
        mlo   = drfm_pkg::MASS_MIN_RST;
        mhi   = drfm_pkg::MASS_MAX_RST;
        slo   = drfm_pkg::SCORE_MIN_RST;
        shi   = drfm_pkg::SCORE_MAX_RST;
        mflag = '0;
        sflag = '0;
      end
      1: begin
        thr_d = '0;
        mflag = 16'd1;
      end
      2: begin
        // all ones: upper bits must be dropped
        thr_d = '1;
        mflag = 16'd1;
        sflag = 16'd1;
      end
      4: begin
        // empty windows: min equal to max, and min above max
        mhi   = mlo;
        slo   = '1;
        shi   = '0;
        mflag = 16'd1;
        sflag = 16'd1;
      end
      6: begin
        mlo   = '0;
        mhi   = '1;
        slo   = '0;
        shi   = '1;
        mflag = 16'd1;
        sflag = 16'd1;
      end
      7: begin
        thr_d = drfm_pkg::CFG_DATA_W'($urandom);
        mflag = drfm_pkg::CFG_DATA_W'($urandom);
        sflag = drfm_pkg::CFG_DATA_W'($urandom);
        cfg_write(REG_UNUSED, drfm_pkg::CFG_DATA_W'($urandom));
      end
      default: ;
    endcase
    cfg_write(drfm_pkg::REG_DR_THRESHOLD, thr_d);
    cfg_write(drfm_pkg::REG_MASS_MIN, mlo);
    cfg_write(drfm_pkg::REG_MASS_MAX, mhi);
    cfg_write(drfm_pkg::REG_SCORE_MIN, slo);
    cfg_write(drfm_pkg::REG_SCORE_MAX, shi);
    cfg_write(drfm_pkg::REG_USE_MASS_WINDOW, mflag);
    cfg_write(drfm_pkg::REG_USE_SCORE_WINDOW, sflag);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic gen_event();
    cand_item_t    it;
    match_result_t unused;
    int            shape;
    int            len;
    int            k;
    int            phi_v;
    bit            noisy;
    unused = '{default: '0};
    noisy  = $urandom_range(99) < 15;
    shape  = $urandom_range(99);
    len    = (shape < 10) ? 1 : (shape < 88) ? $urandom_range(1, 6) : $urandom_range(14, 20);
    for (k = 0; k < len; k++) begin
      it.first   = noisy ? ($urandom_range(3) == 0) : (k == 0);
      it.last    = noisy ? ($urandom_range(3) == 0) : (k == len - 1);
      it.present = (shape >= 10) && ($urandom_range(99) >= 8);
      it.ref_eta = drfm_pkg::ETA_W'($urandom);
      it.ref_phi = drfm_pkg::PHI_W'($urandom);
      if (it.first) begin
        case ($urandom_range(9))
          0: ;
          1: begin
            // reference close to the seam at +/- pi
            phi_v = drfm_pkg::PI_Q10 - int'($urandom_range(200));
            if ($urandom_range(1))
              phi_v = -phi_v;
            it.ref_eta = drfm_pkg::ETA_W'(int'($urandom_range(2 * ETA_SPAN)) - ETA_SPAN);
            it.ref_phi = drfm_pkg::PHI_W'(phi_v);
          end
          default: begin
            it.ref_eta = drfm_pkg::ETA_W'(int'($urandom_range(2 * ETA_SPAN)) - ETA_SPAN);
            it.ref_phi = drfm_pkg::PHI_W'(int'($urandom_range(drfm_pkg::TWO_PI_Q10)) -
                                          drfm_pkg::PI_Q10);
          end
        endcase
        gen_ref_eta = it.ref_eta;
        gen_ref_phi = it.ref_phi;
      end
      case ($urandom_range(19))
        0: begin
          it.cand_eta = drfm_pkg::ETA_W'($urandom);
          it.cand_phi = drfm_pkg::PHI_W'($urandom);
        end
        1, 2, 3, 4, 5, 6, 7: begin
          it.cand_eta = drfm_pkg::ETA_W'(int'($urandom_range(2 * ETA_SPAN)) - ETA_SPAN);
          it.cand_phi = drfm_pkg::PHI_W'(int'($urandom_range(drfm_pkg::TWO_PI_Q10)) -
                                         drfm_pkg::PI_Q10);
        end
        default: begin
          it.cand_eta = drfm_pkg::ETA_W'(int'(gen_ref_eta) +
                                         int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
          it.cand_phi = drfm_pkg::PHI_W'(int'(gen_ref_phi) +
                                         int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
        end
      endcase
      it.cand_mass  = pick_near(mass_lo, mass_hi);
      it.cand_score = pick_near(score_lo, score_hi);
      offer_item(it, 1'b0, unused);
    end
  endtask

  // result side: random back-pressure, plus one long hold when asked
  initial begin : result_sink
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= steady_recv || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    match_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        log_fault($sformatf("result with nothing pending: found=%0b index=%0d overflow=%0b",
                            res_ch.found, res_ch.match_index, res_ch.overflow));
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (want.found)
          found_seen++;
        if (want.overflow)
          overflow_seen++;
        if (res_ch.found !== want.found || res_ch.match_index !== want.match_index ||
            res_ch.overflow !== want.overflow)
          log_fault($sformatf({"mismatch on result %0d: expected found=%0b index=%0d ",
                               "overflow=%0b, got found=%0b index=%0d overflow=%0b"},
                              results_seen, want.found, want.match_index, want.overflow,
                              res_ch.found, res_ch.match_index, res_ch.overflow));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_results.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    cand_item_t    closer;
    match_result_t unused;
    bit            cfg_open;
    int            ph;
    int            k;
    int            phase_end;

    item_ch.valid      = 1'b0;
    item_ch.first      = 1'b0;
    item_ch.ref_eta    = '0;
    item_ch.ref_phi    = '0;
    item_ch.present    = 1'b0;
    item_ch.cand_eta   = '0;
    item_ch.cand_phi   = '0;
    item_ch.cand_mass  = '0;
    item_ch.cand_score = '0;
    item_ch.last       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    unused             = '{default: '0};
    cfg_open           = 1'b0;

    // an unused register index must leave every setting alone
    add_cfg_row(REG_UNUSED, '1);
    add_row(1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
    add_row(1, 0, 0, 1, 0, 0, 1, 1, 1, 0, 0);
    // phi apart by exactly 2pi wraps to zero
    add_row(1, ETA_SPAN, drfm_pkg::PI_Q10, 1, -ETA_SPAN, 0, 0);
    add_row(0, 0, 0, 1, ETA_SPAN, -drfm_pkg::PI_Q10, 0);
    add_row(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0);
    // distance equal to the limit is not a match, one below is
    add_row(1, 0, 0, 1, int'(drfm_pkg::DR_THRESHOLD_RST), 0, 0);
    add_row(0, 0, 0, 1, int'(drfm_pkg::DR_THRESHOLD_RST) - 1, 0, 1, 1, 1, 1, 0);
    // match on the last slot, then one candidate too many
    for (k = 0; k <= drfm_pkg::MAX_CANDIDATES; k++)
      add_row(k == 0, 0, 0, 1, (k < drfm_pkg::MAX_CANDIDATES - 1) ? ETA_SPAN : 0,
              (k == drfm_pkg::MAX_CANDIDATES - 1) ?
                1 - int'(drfm_pkg::DR_THRESHOLD_RST) : 0,
              k == drfm_pkg::MAX_CANDIDATES, k == drfm_pkg::MAX_CANDIDATES, 1,
              drfm_pkg::MAX_CANDIDATES - 1, 1,
              k[0] ? 'hFFFF : 0, k[0] ? 0 : 'hFFFF);
    add_cfg_row(drfm_pkg::REG_DR_THRESHOLD, '1);
    // phi difference beyond 2pi, fields at their full-width extremes
    add_row(1, -(1 << (drfm_pkg::ETA_W - 1)), (1 << (drfm_pkg::PHI_W - 1)) - 1, 1,
            -(1 << (drfm_pkg::ETA_W - 1)), -(1 << (drfm_pkg::PHI_W - 1)), 1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!cfg_open)
          settle();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_ch.valid <= 1'b0;
          cfg_open = 1'b0;
          settings_used++;
        end
        offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      configure_phase(ph);
      steady_send = (ph == PH_PRESSURE) || (ph == PH_STEADY);
      steady_recv = (ph == PH_STEADY);
      if (ph == PH_PRESSURE)
        hold_request = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end)
        gen_event();
      // close any open event before the next register change
      closer            = '{default: '0};
      closer.cand_mass  = drfm_pkg::MASS_W'($urandom);
      closer.cand_score = drfm_pkg::SCORE_W'($urandom);
      closer.last       = 1'b1;
      offer_item(closer, 1'b0, unused);
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;

    settle();
    $display("ran %0d items under %0d register settings, with one %0d-cycle result stall",
             items_sent, settings_used, HOLD_CYCLES);
    $display("checked %0d results: %0d with a match, %0d overflowed, %0d faults",
             results_seen, found_seen, overflow_seen, fault_count);
    if (fault_count == 0 && expected_results.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
